/* design/tlft_pkg.sv */
// ----------------------------------------------------------------------------
// tlft_pkg
// Shared types and codes for the two-lane finish timer: item opcodes, the
// reported phase, winner codes and the widths of the item fields.
// ----------------------------------------------------------------------------
`default_nettype none

package tlft_pkg;

  localparam int unsigned DistW   = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned ThreshW = 13;
  localparam int unsigned WindowW = 16;
  localparam int unsigned CfgW    = 16;

  localparam logic [ThreshW-1:0] ThreshReset = 13'd100;
  localparam logic [WindowW-1:0] WindowReset = 16'd0;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    PH_WAITING  = 2'd0,
    PH_READY    = 2'd1,
    PH_RACING   = 2'd2,
    PH_FINISHED = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    WIN_NONE = 2'd0,
    WIN_A    = 2'd1,
    WIN_B    = 2'd2,
    WIN_TIE  = 2'd3
  } winner_t;

  typedef enum logic {
    REG_THRESHOLD  = 1'b0,
    REG_TIE_WINDOW = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [TimeW-1:0] time_ms;
    logic [DistW-1:0] distance_b;
    logic [DistW-1:0] distance_a;
  } in_item_t;

  typedef struct packed {
    logic             pad;
    winner_t          winner;
    logic             race_over;
    logic             lane_b_done;
    logic             lane_a_done;
    logic [TimeW-1:0] elapsed_b;
    logic [TimeW-1:0] elapsed_a;
    phase_t           phase;
  } out_item_t;

endpackage

`default_nettype wire

/* design/two_lane_finish_timer.sv */
// ----------------------------------------------------------------------------
// two_lane_finish_timer
// Times a two-lane race from a stream of load, start and sensor sample beats,
// with a tie window that averages close finishes.
// ----------------------------------------------------------------------------
//  Channel  Direction  Content
//  s_axis   in         tuser: opcode; tdata: distance_a, distance_b, time_ms
//  m_axis   out        tdata: phase, elapsed_a, elapsed_b, lane flags,
//                      race_over, winner (one result beat per input beat)
//  cfg      in         cfg_we / cfg_addr / cfg_wdata, write only
//
//  A beat is taken into an input register, worked combinationally and
//  written with the race state into the result register: one beat per
//  cycle sustained while m_axis_tready is high. The result register parts
//  the two sides, so a new beat is taken while a result waits, and input
//  stalls only when both registers are full and m_axis_tready is low.
//  Synchronous reset clears the race state and loads the register defaults
//  (threshold 100 mm, tie window 0 ms).
// ----------------------------------------------------------------------------
`default_nettype none

module two_lane_finish_timer
  import tlft_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  // [15:0] distance_a, [31:16] distance_b, [63:32] time_ms
  input  wire logic [63:0]     s_axis_tdata,
  // [1:0] opcode
  input  wire logic [1:0]      s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  // [1:0] phase, [33:2] elapsed_a, [65:34] elapsed_b, [66] lane_a_done,
  // [67] lane_b_done, [68] race_over, [70:69] winner, [71] zero
  output logic [71:0]          m_axis_tdata,
  input  wire logic            cfg_we,
  input  wire logic            cfg_addr,
  input  wire logic [CfgW-1:0] cfg_wdata
);

  logic [ThreshW-1:0] threshold;
  logic [WindowW-1:0] tie_window;

  logic             in_valid;
  in_item_t         in_item;
  opcode_t          in_op;
  logic             out_valid;
  out_item_t        out_item;
  logic             advance;

  logic             armed, running, completed_once, done_a, done_b;
  logic [TimeW-1:0] start_stamp, time_a, time_b;
  winner_t          last_winner;

  logic             armed_next, running_next, completed_once_next;
  logic             done_a_next, done_b_next;
  logic [TimeW-1:0] start_stamp_next, time_a_next, time_b_next;
  winner_t          last_winner_next;
  logic             over;
  phase_t           phase_next;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= ThreshReset;
      tie_window <= WindowReset;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_THRESHOLD:  threshold  <= cfg_wdata[ThreshW-1:0];
        REG_TIE_WINDOW: tie_window <= cfg_wdata[WindowW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item <= s_axis_tdata;
      in_op   <= opcode_t'(s_axis_tuser);
    end
  end

  always_comb begin
    logic [TimeW-1:0] lap;
    logic             cross_a, cross_b, late, a_ge, tie;
    logic [TimeW-1:0] ta, tb, gap;
    logic [TimeW:0]   sum;

    armed_next          = armed;
    running_next        = running;
    completed_once_next = completed_once;
    done_a_next         = done_a;
    done_b_next         = done_b;
    start_stamp_next    = start_stamp;
    time_a_next         = time_a;
    time_b_next         = time_b;
    last_winner_next    = last_winner;
    over                = 1'b0;

    lap     = in_item.time_ms - start_stamp;
    cross_a = !done_a && (in_item.distance_a < {{(DistW-ThreshW){1'b0}}, threshold});
    cross_b = !done_b && (in_item.distance_b < {{(DistW-ThreshW){1'b0}}, threshold});
    ta      = cross_a ? lap : time_a;
    tb      = cross_b ? lap : time_b;
    // Only a single late finisher against an already finished lane is averaged.
    late    = (cross_a && !cross_b && done_b) || (cross_b && !cross_a && done_a);
    a_ge    = ta >= tb;
    gap     = a_ge ? (ta - tb) : (tb - ta);
    tie     = late && (gap <= {{(TimeW-WindowW){1'b0}}, tie_window});
    sum     = {1'b0, ta} + {1'b0, tb};

    unique case (in_op)
      OP_LOAD: begin
        armed_next = 1'b1;
      end
      OP_START: begin
        if (armed && !running) begin
          running_next     = 1'b1;
          done_a_next      = 1'b0;
          done_b_next      = 1'b0;
          time_a_next      = '0;
          time_b_next      = '0;
          start_stamp_next = in_item.time_ms;
          last_winner_next = WIN_NONE;
          armed_next       = 1'b0;
        end
      end
      OP_SAMPLE: begin
        if (running) begin
          done_a_next = done_a || cross_a;
          done_b_next = done_b || cross_b;
          time_a_next = tie ? sum[TimeW:1] : ta;
          time_b_next = tie ? sum[TimeW:1] : tb;
          if ((done_a || cross_a) && (done_b || cross_b)) begin
            if (tie || (ta == tb)) begin
              last_winner_next = WIN_TIE;
            end else if (a_ge) begin
              last_winner_next = WIN_B;
            end else begin
              last_winner_next = WIN_A;
            end
            running_next        = 1'b0;
            completed_once_next = 1'b1;
            over                = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (running_next) begin
      phase_next = PH_RACING;
    end else if (armed_next) begin
      phase_next = PH_READY;
    end else if (completed_once_next) begin
      phase_next = PH_FINISHED;
    end else begin
      phase_next = PH_WAITING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed          <= 1'b0;
      running        <= 1'b0;
      completed_once <= 1'b0;
      done_a         <= 1'b0;
      done_b         <= 1'b0;
      start_stamp    <= '0;
      time_a         <= '0;
      time_b         <= '0;
      last_winner    <= WIN_NONE;
    end else if (advance) begin
      armed          <= armed_next;
      running        <= running_next;
      completed_once <= completed_once_next;
      done_a         <= done_a_next;
      done_b         <= done_b_next;
      start_stamp    <= start_stamp_next;
      time_a         <= time_a_next;
      time_b         <= time_b_next;
      last_winner    <= last_winner_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.pad         <= 1'b0;
      out_item.winner      <= last_winner_next;
      out_item.race_over   <= over;
      out_item.lane_b_done <= done_b_next;
      out_item.lane_a_done <= done_a_next;
      out_item.elapsed_b   <= time_b_next;
      out_item.elapsed_a   <= time_a_next;
      out_item.phase       <= phase_next;
    end
  end

endmodule

`default_nettype wire
